// ----- src/planar_pose_compose_assert.svh -----
// Assertion macros shared by the planar pose compose RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef PLANAR_POSE_COMPOSE_ASSERT_SVH
`define PLANAR_POSE_COMPOSE_ASSERT_SVH

// Same-cycle implication.
`define PPC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppc: implication check failed");

// Next-cycle implication.
`define PPC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppc: next-cycle check failed");

`endif

// ----- src/ppc_pkg.sv -----
// ---------------------------------------------------------------------------
// ppc_pkg
// Types, widths and CORDIC helpers for the planar pose compose pipeline.
// ---------------------------------------------------------------------------
package ppc_pkg;

	localparam int POS_W    = 32;
	localparam int ANG_W    = 16;
	localparam int GUARD    = 8;
	localparam int DP_W     = 44;
	localparam int Z_W      = 34;
	localparam int ITERS    = ANG_W;
	localparam int PER_STG  = 2;
	localparam int CSTG     = ITERS / PER_STG;
	localparam int GAIN_W   = 30;
	localparam int HI_W     = DP_W - GAIN_W;
	localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

	typedef struct packed {
		logic signed [POS_W-1:0] first_x;
		logic signed [POS_W-1:0] first_y;
		logic signed [ANG_W-1:0] first_heading;
		logic signed [POS_W-1:0] second_x;
		logic signed [POS_W-1:0] second_y;
		logic signed [ANG_W-1:0] second_heading;
	} pose_t;

	typedef struct packed {
		logic signed [POS_W-1:0] result_x;
		logic signed [POS_W-1:0] result_y;
		logic signed [ANG_W-1:0] result_heading;
		logic                    saturated;
	} result_t;

	// Values carried alongside the rotation.
	typedef struct packed {
		logic signed [POS_W-1:0] ox;
		logic signed [POS_W-1:0] oy;
		logic signed [ANG_W-1:0] hsum;
	} side_t;

	typedef struct packed {
		logic signed [DP_W-1:0] x;
		logic signed [DP_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		side_t                  side;
	} cordic_t;

	// Split gain products for one coordinate.
	typedef struct packed {
		logic [DP_W-1:0]   hik;
		logic [GAIN_W-1:0] lok;
		logic              neg;
	} gprod_t;

	typedef struct packed {
		gprod_t gx;
		gprod_t gy;
		side_t  side;
	} gain_t;

	// atan(2^-i) in a 32-bit turn (2^31 = pi)
	function automatic logic signed [Z_W-1:0] atan_turn(input int i);
		logic signed [Z_W-1:0] r;
		case (i)
			0:  r = 34'sd536870912;
			1:  r = 34'sd316933406;
			2:  r = 34'sd167458907;
			3:  r = 34'sd85004756;
			4:  r = 34'sd42667331;
			5:  r = 34'sd21354465;
			6:  r = 34'sd10680862;
			7:  r = 34'sd5340245;
			8:  r = 34'sd2670675;
			9:  r = 34'sd1335343;
			10: r = 34'sd667544;
			11: r = 34'sd333772;
			12: r = 34'sd166886;
			13: r = 34'sd83443;
			14: r = 34'sd41722;
			15: r = 34'sd20861;
			16: r = 34'sd10430;
			17: r = 34'sd5215;
			18: r = 34'sd2608;
			19: r = 34'sd1304;
			20: r = 34'sd652;
			21: r = 34'sd326;
			22: r = 34'sd163;
			23: r = 34'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic cordic_t cordic_iter(input cordic_t c, input int i);
		cordic_t r;
		logic signed [DP_W-1:0] dx;
		logic signed [DP_W-1:0] dy;
		r  = c;
		dx = c.y >>> i;
		dy = c.x >>> i;
		if (!c.z[Z_W-1]) begin
			r.x = c.x - dx;
			r.y = c.y + dy;
			r.z = c.z - atan_turn(i);
		end else begin
			r.x = c.x + dx;
			r.y = c.y - dy;
			r.z = c.z + atan_turn(i);
		end
		return r;
	endfunction

endpackage

// ----- src/ppc_cordic.sv -----
// ---------------------------------------------------------------------------
// ppc_cordic
// Pipelined CORDIC rotation, two micro-rotations per register stage.
// ---------------------------------------------------------------------------
module ppc_cordic (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  ppc_pkg::cordic_t in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output ppc_pkg::cordic_t out_data
);
	import ppc_pkg::*;

	logic    [CSTG-1:0] v_s;
	cordic_t            d_s [CSTG];
	logic    [CSTG:0]   st;

	assign st[CSTG] = out_stall;

	for (genvar s = 0; s < CSTG; s++) begin : g_stage
		logic    vin;
		cordic_t din;
		cordic_t dnext;

		if (s == 0) begin : g_first
			assign vin = in_valid;
			assign din = in_data;
		end else begin : g_rest
			assign vin = v_s[s-1];
			assign din = d_s[s-1];
		end

		assign st[s] = v_s[s] && st[s+1];

		always_comb begin
			dnext = din;
			for (int k = 0; k < PER_STG; k++) begin
				dnext = cordic_iter(dnext, s * PER_STG + k);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[s] <= 1'b0;
			end else if (!st[s]) begin
				v_s[s] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (!st[s]) begin
				d_s[s] <= dnext;
			end
		end
	end

	assign in_stall  = st[0];
	assign out_valid = v_s[CSTG-1];
	assign out_data  = d_s[CSTG-1];

endmodule

// ----- src/ppc_gain.sv -----
// ---------------------------------------------------------------------------
// ppc_gain
// CORDIC gain correction: magnitude split, then split products per lane.
// ---------------------------------------------------------------------------
module ppc_gain (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  ppc_pkg::cordic_t in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output ppc_pkg::gain_t   out_data
);
	import ppc_pkg::*;

	typedef struct packed {
		logic [DP_W-1:0] mx;
		logic [DP_W-1:0] my;
		logic            nx;
		logic            ny;
		side_t           side;
	} mag_t;

	logic  v_s1, v_s2;
	logic  st_s1, st_s2;
	mag_t  m_s1;
	gain_t g_s2;
	gain_t g_next;

	function automatic gprod_t split_mul(input logic [DP_W-1:0] m, input logic n);
		gprod_t                   r;
		logic [HI_W+GAIN_W-1:0]   ph;
		logic [2*GAIN_W-1:0]      pl;
		ph    = m[DP_W-1:GAIN_W] * GAIN_Q30;
		pl    = m[GAIN_W-1:0] * GAIN_Q30;
		r.hik = ph[DP_W-1:0];
		r.lok = pl[2*GAIN_W-1:GAIN_W];
		r.neg = n;
		return r;
	endfunction

	assign st_s2 = v_s2 && out_stall;
	assign st_s1 = v_s1 && st_s2;

	always_comb begin
		g_next.gx   = split_mul(m_s1.mx, m_s1.nx);
		g_next.gy   = split_mul(m_s1.my, m_s1.ny);
		g_next.side = m_s1.side;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (!st_s1) v_s1 <= in_valid;
			if (!st_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!st_s1) begin
			m_s1.nx   <= in_data.x[DP_W-1];
			m_s1.ny   <= in_data.y[DP_W-1];
			m_s1.mx   <= in_data.x[DP_W-1] ? -in_data.x : in_data.x;
			m_s1.my   <= in_data.y[DP_W-1] ? -in_data.y : in_data.y;
			m_s1.side <= in_data.side;
		end
		if (!st_s2) begin
			g_s2 <= g_next;
		end
	end

	assign in_stall  = st_s1;
	assign out_valid = v_s2;
	assign out_data  = g_s2;

endmodule

// ----- src/planar_pose_compose.sv -----
// ---------------------------------------------------------------------------
// planar_pose_compose
// Composes two planar poses: rotate second translation, add first one.
// ---------------------------------------------------------------------------
// Usage:
//   req carries both poses; it is taken on a clock edge with req_valid high
//   and req_stall low. rsp carries the composed pose and a saturation flag;
//   it is taken on an edge with rsp_valid high and rsp_stall low.
//   The pipe has 13 register stages: one for the quadrant fold, eight CORDIC
//   stages of two micro-rotations each, two gain-correction stages and two
//   stages for offset, rounding and clamp. Throughput is one transaction
//   per cycle while req_stall is low; every stage is a register with its
//   own valid bit, so bubbles are filled while a later stage holds.
//   When the receiver stalls, the last stage holds its result and earlier
//   stages keep loading until the pipe is full; only then is req_stall
//   raised. Reset clears every valid bit; the block takes a request in the
//   first cycle after reset.
// ---------------------------------------------------------------------------
module planar_pose_compose (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  ppc_pkg::pose_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output ppc_pkg::result_t rsp
);
	import ppc_pkg::*;

	localparam logic signed [DP_W-1:0] RND   = DP_W'(1) <<< (GUARD - 1);
	localparam logic signed [DP_W-GUARD-1:0] POS_MAX =
		(DP_W-GUARD)'((64'sd1 <<< (POS_W - 1)) - 1);
	localparam logic signed [DP_W-GUARD-1:0] POS_MIN =
		(DP_W-GUARD)'(-(64'sd1 <<< (POS_W - 1)));

	typedef struct packed {
		logic signed [DP_W-1:0] sx;
		logic signed [DP_W-1:0] sy;
		logic signed [ANG_W-1:0] hsum;
	} sum_t;

	// Fold stage
	logic    v_s1, st_s1;
	cordic_t f_s1;
	cordic_t f_next;
	logic    fold;
	logic signed [DP_W-1:0] x2e, y2e;
	logic signed [ANG_W-1:0] a;

	always_comb begin
		fold = req.first_heading[ANG_W-1] != req.first_heading[ANG_W-2];
		x2e  = DP_W'(req.second_x) <<< GUARD;
		y2e  = DP_W'(req.second_y) <<< GUARD;
		a    = req.first_heading;
		if (fold) begin
			a[ANG_W-1] = ~a[ANG_W-1];
			x2e        = -x2e;
			y2e        = -y2e;
		end
		f_next.x         = x2e;
		f_next.y         = y2e;
		f_next.z         = Z_W'(a) <<< (32 - ANG_W);
		f_next.side.ox   = req.first_x;
		f_next.side.oy   = req.first_y;
		f_next.side.hsum = req.first_heading + req.second_heading;
	end

	logic    c_valid, c_stall;
	cordic_t c_data;
	logic    g_valid, g_stall, c_in_stall;
	gain_t   g_data;

	ppc_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_stall  (c_in_stall),
		.in_data   (f_s1),
		.out_valid (c_valid),
		.out_stall (c_stall),
		.out_data  (c_data)
	);

	ppc_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c_valid),
		.in_stall  (c_stall),
		.in_data   (c_data),
		.out_valid (g_valid),
		.out_stall (g_stall),
		.out_data  (g_data)
	);

	// Offset and round stage, then clamp into the output register
	logic    v_s2, st_s2, v_s3, st_s3;
	sum_t    s_s2, s_next;
	result_t r_s3, r_next;

	function automatic logic signed [DP_W-1:0] finish_sum(input gprod_t g,
			input logic signed [POS_W-1:0] off);
		logic signed [DP_W-1:0] r;
		r = g.hik + DP_W'(g.lok);
		if (g.neg) r = -r;
		return r + (DP_W'(off) <<< GUARD) + RND;
	endfunction

	function automatic logic signed [POS_W:0] clamp(input logic signed [DP_W-1:0] s);
		logic signed [DP_W-GUARD-1:0] t;
		logic signed [POS_W:0]        r;
		t = s[DP_W-1:GUARD];
		if (t > POS_MAX)      r = {1'b1, POS_MAX[POS_W-1:0]};
		else if (t < POS_MIN) r = {1'b1, POS_MIN[POS_W-1:0]};
		else                  r = {1'b0, t[POS_W-1:0]};
		return r;
	endfunction

	logic signed [POS_W:0] cx, cy;

	always_comb begin
		s_next.sx   = finish_sum(g_data.gx, g_data.side.ox);
		s_next.sy   = finish_sum(g_data.gy, g_data.side.oy);
		s_next.hsum = g_data.side.hsum;
		cx          = clamp(s_s2.sx);
		cy          = clamp(s_s2.sy);
		r_next.result_x       = cx[POS_W-1:0];
		r_next.result_y       = cy[POS_W-1:0];
		r_next.result_heading = s_s2.hsum;
		r_next.saturated      = cx[POS_W] | cy[POS_W];
	end

	assign st_s3     = v_s3 && rsp_stall;
	assign st_s2     = v_s2 && st_s3;
	assign g_stall   = st_s2;
	assign st_s1     = v_s1 && c_in_stall;
	assign req_stall = st_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (!st_s1) v_s1 <= req_valid;
			if (!st_s2) v_s2 <= g_valid;
			if (!st_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!st_s1) f_s1 <= f_next;
		if (!st_s2) s_s2 <= s_next;
		if (!st_s3) r_s3 <= r_next;
	end

	assign rsp_valid = v_s3;
	assign rsp       = r_s3;

`include "planar_pose_compose_assert.svh"

	`PPC_ASSERT_IMP(a_full_when_stalled, req_stall, rsp_valid && rsp_stall)
	`PPC_ASSERT_NXT(a_fold_holds, v_s1 && st_s1, v_s1 && $stable(f_s1))
	`PPC_ASSERT_IMP(a_sat_at_limit, rsp_valid && rsp.saturated,
		rsp.result_x == POS_MAX[POS_W-1:0] || rsp.result_x == POS_MIN[POS_W-1:0] ||
		rsp.result_y == POS_MAX[POS_W-1:0] || rsp.result_y == POS_MIN[POS_W-1:0])

endmodule
